[rtl/core/dma_disk_sector_controller_unit_macros.svh]
`ifndef DMA_DISK_SECTOR_CONTROLLER_UNIT_MACROS_SVH
`define DMA_DISK_SECTOR_CONTROLLER_UNIT_MACROS_SVH

// Checks that are meaningful only once reset has been released.
`define DMADSC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checks that must also hold while reset is asserted.
`define DMADSC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/dmadsc_pkg.sv]
package dmadsc_pkg;

  localparam logic [2:0] CMD_TICK      = 3'd0;
  localparam logic [2:0] CMD_START_RD  = 3'd1;
  localparam logic [2:0] CMD_START_WR  = 3'd2;
  localparam logic [2:0] CMD_DATA_RET  = 3'd3;
  localparam logic [2:0] CMD_PRELOAD   = 3'd4;
  localparam logic [2:0] CMD_CLEAR_IRQ = 3'd5;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_WAIT = 2'd1;
  localparam logic [1:0] PH_XFER = 2'd2;
  localparam logic [1:0] PH_RET  = 2'd3;

  localparam int SECTOR_W  = 7;
  localparam int MADDR_W   = 12;
  localparam int DATA_W    = 32;
  localparam int CMD_W     = 3;

endpackage

[rtl/core/dmadsc_ram.sv]
module dmadsc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/dma_disk_sector_controller_unit.sv]
// Channel   Direction  Handshake            Payload
// request   in         in_valid / in_ready  command, sector, word_index, buffer_address,
//                                           mem_data
// result    out        out_valid / out_ready mem_write_valid, mem_read_valid, mem_address,
//                                           write_data, busy_res, irq, error
//
// The sector store is read in the cycle of acceptance and the request is completed, with
// any store write, in the next cycle.
// A new request is taken while the previous result is being handed over.
// After reset the store is swept to zero, one word a cycle, over all
// SECTOR_COUNT * SECTOR_WORDS words; no request is accepted during the sweep.
// A stalled result holds the block until it is taken.
`include "dma_disk_sector_controller_unit_macros.svh"

module dma_disk_sector_controller_unit #(
  parameter int SECTOR_COUNT  = 128,
  parameter int SECTOR_WORDS  = 128,
  parameter int OP_TICKS      = 1024,
  parameter int MEM_ADDR_BITS = 12
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [dmadsc_pkg::CMD_W-1:0]         command,
  input  logic [dmadsc_pkg::SECTOR_W-1:0]      sector,
  input  logic [dmadsc_pkg::SECTOR_W-1:0]      word_index,
  input  logic [dmadsc_pkg::MADDR_W-1:0]       buffer_address,
  input  logic [dmadsc_pkg::DATA_W-1:0]        mem_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 mem_write_valid,
  output logic                                 mem_read_valid,
  output logic [dmadsc_pkg::MADDR_W-1:0]       mem_address,
  output logic [dmadsc_pkg::DATA_W-1:0]        write_data,
  output logic                                 busy_res,
  output logic                                 irq,
  output logic                                 error
);

  localparam int DEPTH   = SECTOR_COUNT * SECTOR_WORDS;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int WC_W    = (SECTOR_WORDS > 1) ? $clog2(SECTOR_WORDS) : 1;
  localparam int TIMER_W = (OP_TICKS > 0) ? $clog2(OP_TICKS + 1) : 1;
  localparam int SUM_W   = dmadsc_pkg::MADDR_W + 1;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
  localparam logic [WC_W-1:0] LAST_WORD = WC_W'(SECTOR_WORDS - 1);
  localparam logic [dmadsc_pkg::MADDR_W-1:0] ADDR_MASK =
    (MEM_ADDR_BITS >= dmadsc_pkg::MADDR_W) ? {dmadsc_pkg::MADDR_W{1'b1}} :
    dmadsc_pkg::MADDR_W'((64'd1 << MEM_ADDR_BITS) - 64'd1);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;

  logic [1:0]                         state;
  logic [ADDR_W-1:0]                  clear_addr;
  logic [1:0]                         phase;
  logic [1:0]                         phase_next;
  logic                               op_write;
  logic                               op_write_next;
  logic [TIMER_W-1:0]                 busy_timer;
  logic [TIMER_W-1:0]                 busy_timer_next;
  logic [WC_W-1:0]                    wc;
  logic [WC_W-1:0]                    wc_next;
  logic [dmadsc_pkg::SECTOR_W-1:0]    cur_sector;
  logic [dmadsc_pkg::SECTOR_W-1:0]    cur_sector_next;
  logic [dmadsc_pkg::MADDR_W-1:0]     buf_base;
  logic [dmadsc_pkg::MADDR_W-1:0]     buf_base_next;
  logic                               irq_flag;
  logic                               irq_flag_next;

  logic [dmadsc_pkg::CMD_W-1:0]       cmd_q;
  logic [dmadsc_pkg::SECTOR_W-1:0]    sec_q;
  logic [dmadsc_pkg::SECTOR_W-1:0]    widx_q;
  logic [dmadsc_pkg::MADDR_W-1:0]     base_q;
  logic [dmadsc_pkg::DATA_W-1:0]      data_q;

  logic                               accept;
  logic [ADDR_W-1:0]                  slot;
  logic [ADDR_W-1:0]                  preload_slot;
  logic [SUM_W-1:0]                   addr_sum;
  logic [dmadsc_pkg::MADDR_W-1:0]     dma_addr;
  logic                               sec_ok;
  logic                               preload_ok;

  logic                               exec_we;
  logic [ADDR_W-1:0]                  exec_waddr;
  logic                               ram_we;
  logic [ADDR_W-1:0]                  ram_waddr;
  logic [dmadsc_pkg::DATA_W-1:0]      ram_wdata;
  logic [dmadsc_pkg::DATA_W-1:0]      ram_rdata;

  logic                               wv_c;
  logic                               rv_c;
  logic [dmadsc_pkg::MADDR_W-1:0]     addr_c;
  logic [dmadsc_pkg::DATA_W-1:0]      wdata_c;
  logic                               err_c;

  assign in_ready = (state == ST_IDLE) && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  assign slot = ADDR_W'(cur_sector) * ADDR_W'(SECTOR_WORDS) + ADDR_W'(wc);
  assign preload_slot = ADDR_W'(sec_q) * ADDR_W'(SECTOR_WORDS) + ADDR_W'(widx_q);
  assign addr_sum = SUM_W'(buf_base) + SUM_W'(wc);
  assign dma_addr = addr_sum[dmadsc_pkg::MADDR_W-1:0] & ADDR_MASK;
  assign sec_ok = 32'(sec_q) < 32'(SECTOR_COUNT);
  assign preload_ok = sec_ok && (32'(widx_q) < 32'(SECTOR_WORDS));

  always_comb begin
    phase_next      = phase;
    op_write_next   = op_write;
    busy_timer_next = busy_timer;
    wc_next         = wc;
    cur_sector_next = cur_sector;
    buf_base_next   = buf_base;
    irq_flag_next   = irq_flag;
    exec_we         = 1'b0;
    exec_waddr      = slot;
    wv_c            = 1'b0;
    rv_c            = 1'b0;
    addr_c          = '0;
    wdata_c         = '0;
    err_c           = 1'b0;
    case (cmd_q)
      dmadsc_pkg::CMD_TICK: begin
        if (phase == dmadsc_pkg::PH_WAIT) begin
          if (32'(busy_timer) < 32'(OP_TICKS)) begin
            busy_timer_next = busy_timer + TIMER_W'(1);
          end else begin
            busy_timer_next = '0;
            wc_next         = '0;
            phase_next      = dmadsc_pkg::PH_XFER;
          end
        end else if (phase == dmadsc_pkg::PH_XFER) begin
          addr_c = dma_addr;
          if (op_write) begin
            rv_c       = 1'b1;
            phase_next = dmadsc_pkg::PH_RET;
          end else begin
            wv_c    = 1'b1;
            wdata_c = ram_rdata;
            if (wc == LAST_WORD) begin
              phase_next    = dmadsc_pkg::PH_IDLE;
              wc_next       = '0;
              irq_flag_next = 1'b1;
            end else begin
              wc_next    = wc + WC_W'(1);
              phase_next = dmadsc_pkg::PH_XFER;
            end
          end
        end
      end
      dmadsc_pkg::CMD_START_RD, dmadsc_pkg::CMD_START_WR: begin
        if (phase != dmadsc_pkg::PH_IDLE || !sec_ok) begin
          err_c = 1'b1;
        end else begin
          op_write_next   = (cmd_q == dmadsc_pkg::CMD_START_WR);
          cur_sector_next = sec_q;
          buf_base_next   = base_q;
          busy_timer_next = '0;
          wc_next         = '0;
          phase_next      = dmadsc_pkg::PH_WAIT;
        end
      end
      dmadsc_pkg::CMD_DATA_RET: begin
        if (phase != dmadsc_pkg::PH_RET) begin
          err_c = 1'b1;
        end else begin
          exec_we = 1'b1;
          if (wc == LAST_WORD) begin
            phase_next    = dmadsc_pkg::PH_IDLE;
            wc_next       = '0;
            irq_flag_next = 1'b1;
          end else begin
            wc_next    = wc + WC_W'(1);
            phase_next = dmadsc_pkg::PH_XFER;
          end
        end
      end
      dmadsc_pkg::CMD_PRELOAD: begin
        if (preload_ok) begin
          exec_we    = 1'b1;
          exec_waddr = preload_slot;
        end
      end
      dmadsc_pkg::CMD_CLEAR_IRQ: begin
        irq_flag_next = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (state == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clear_addr;
      ram_wdata = '0;
    end else begin
      ram_we    = (state == ST_EXEC) && exec_we;
      ram_waddr = exec_waddr;
      ram_wdata = data_q;
    end
  end

  dmadsc_ram #(
    .WIDTH(dmadsc_pkg::DATA_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(slot),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clear_addr <= '0;
      phase      <= dmadsc_pkg::PH_IDLE;
      op_write   <= 1'b0;
      busy_timer <= '0;
      wc         <= '0;
      cur_sector <= '0;
      buf_base   <= '0;
      irq_flag   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clear_addr <= clear_addr + ADDR_W'(1);
          if (clear_addr == LAST_ADDR) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          phase      <= phase_next;
          op_write   <= op_write_next;
          busy_timer <= busy_timer_next;
          wc         <= wc_next;
          cur_sector <= cur_sector_next;
          buf_base   <= buf_base_next;
          irq_flag   <= irq_flag_next;
          out_valid  <= 1'b1;
          state      <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q  <= command;
      sec_q  <= sector;
      widx_q <= word_index;
      base_q <= buffer_address;
      data_q <= mem_data;
    end
    if (state == ST_EXEC) begin
      mem_write_valid <= wv_c;
      mem_read_valid  <= rv_c;
      mem_address     <= addr_c;
      write_data      <= wdata_c;
      busy_res        <= (phase_next != dmadsc_pkg::PH_IDLE);
      irq             <= irq_flag_next;
      error           <= err_c;
    end
  end

  `DMADSC_ASSERT(a_accept_then_exec, (in_valid && in_ready) |=> (state == ST_EXEC), "accepted request not executed")
  `DMADSC_ASSERT(a_exec_gives_result, (state == ST_EXEC) |=> out_valid, "executed request produced no result")
  `DMADSC_ASSERT(a_one_bus_request, out_valid |-> !(mem_write_valid && mem_read_valid), "read and write request together")
  `DMADSC_ASSERT(a_error_no_bus, (out_valid && error) |-> (!mem_write_valid && !mem_read_valid), "refused command issued a bus request")
  `DMADSC_ASSERT_ALWAYS(a_clear_blocks_input, (state == ST_CLEAR) |=> !(in_valid && in_ready && $past(state) == ST_CLEAR && state == ST_CLEAR), "request accepted during store clearing")

endmodule
